FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] data_value;
    logic signed [31:0] priority_value;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] head_data;
    logic signed [31:0] head_priority;
    logic [4:0]         occupancy;
  } result_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  // Chain-wide control broadcast to every cell.
  typedef struct packed {
    logic   insert_en;
    logic   remove_en;
    entry_t new_entry;
  } ctrl_t;

endpackage

FILE: sv/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic   clk_i,
  input  ctrl_t  ctrl_i,
  input  logic   valid_i,
  input  logic   left_ge_i,
  input  entry_t left_entry_i,
  input  entry_t right_entry_i,
  output logic   ge_o,
  output entry_t entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  // A held entry with priority at least the new one stays ahead of it.
  assign ge_o = valid_i && (entry_q.prio >= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert_en) begin
      if (!ge_o) begin
        entry_d = left_ge_i ? ctrl_i.new_entry : left_entry_i;
      end
    end else if (ctrl_i.remove_en) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: sv/sorted_priority_queue.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// The result strobe done_o is registered and rises in the cycle after the command transfer.
// Throughput: one command per cycle; busy is never asserted, since every cell
// compares against the new priority and shifts in the same cycle.
// Reset clears the entry count and the result strobe; the entry cells are not
// cleared. The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  output logic    done_o,
  output result_t result_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          done_q;
  result_t       result_q, result_d;
  ctrl_t         ctrl;
  logic          accept;
  logic          full, empty;

  entry_t        cell_entry [QUEUE_DEPTH];
  logic          cell_ge    [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    ctrl.insert_en      = accept && (cmd_i.mode == MODE_INSERT) && !full;
    ctrl.remove_en      = accept && (cmd_i.mode == MODE_REMOVE) && !empty;
    ctrl.new_entry.data = cmd_i.data_value;
    ctrl.new_entry.prio = cmd_i.priority_value;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_entry = ctrl.new_entry;
    end else begin : g_inner
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    // The last cell refills with its own contents, which fall outside the count.
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (CW'(i) < count_q),
      .left_ge_i    (left_ge),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .ge_o         (cell_ge[i]),
      .entry_o      (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert_en) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.remove_en) begin
      count_d = count_q - CW'(1);
    end else if (accept && (cmd_i.mode == MODE_CLEAR)) begin
      count_d = '0;
    end
  end

  always_comb begin
    result_d.status        = STATUS_OK;
    result_d.head_data     = '0;
    result_d.head_priority = '0;
    result_d.occupancy     = 5'(count_d);
    case (cmd_i.mode)
      MODE_INSERT: begin
        if (full) begin
          result_d.status = STATUS_FULL;
        end
      end
      MODE_REMOVE, MODE_PEEK: begin
        if (empty) begin
          result_d.status = STATUS_UNDERFLOW;
        end else begin
          result_d.head_data     = cell_entry[0].data;
          result_d.head_priority = cell_entry[0].prio;
        end
      end
      default: begin
        result_d.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted command produced no result strobe");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.mode == MODE_INSERT && full) |=>
      (count_q == $past(count_q)) && (result_o.status == STATUS_FULL))
    else $error("insert on a full queue changed the state");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
    else $error("head entries out of priority order");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_CMDS = 880;
  localparam int BLOCK_CMDS  = 55;

  // Mirrors the queue contents and holds the results still owed by the block.
  class spq_scoreboard;
    entry_t  held[$];
    result_t awaited[$];
    int      errors;

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %0s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    function void note_cmd(cmd_t c);
      result_t r;
      entry_t  e;
      int      pos;
      r = '0;
      r.status = STATUS_OK;
      case (c.mode)
        MODE_INSERT: begin
          if (held.size() >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            // Equal priorities stay in arrival order, so skip past them.
            pos = 0;
            while (pos < held.size() &&
                   $signed(held[pos].prio) >= $signed(c.priority_value))
              pos++;
            e.data = c.data_value;
            e.prio = c.priority_value;
            held.insert(pos, e);
          end
        end
        MODE_REMOVE, MODE_PEEK: begin
          if (held.size() == 0) begin
            r.status = STATUS_UNDERFLOW;
          end else begin
            r.head_data     = held[0].data;
            r.head_priority = held[0].prio;
            if (c.mode == MODE_REMOVE) void'(held.pop_front());
          end
        end
        default: held.delete();
      endcase
      r.occupancy = 5'(held.size());
      awaited.push_back(r);
    endfunction

    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report("result with none pending", 32'(got.occupancy), 32'd0);
      end else begin
        want = awaited.pop_front();
        if (got.status != want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.head_data != want.head_data)
          report("head_data", got.head_data, want.head_data);
        if (got.head_priority != want.head_priority)
          report("head_priority", got.head_priority, want.head_priority);
        if (got.occupancy != want.occupancy)
          report("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      end
    endtask
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  cmd_t    cmd_i;
  logic    done_o;
  result_t result_o;

  spq_scoreboard sb;
  bit            no_gaps;

  sorted_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #500000;
    $display("FAIL sorted_priority_queue");
    $finish;
  end

  always @(posedge clk_i) begin
    if (sb != null) begin
      if (rst_ni && start && !busy) sb.note_cmd(cmd_i);
      if (done_o) sb.check_result(result_o);
    end
  end

  function automatic cmd_t mk_cmd(mode_e m, logic [31:0] d, logic [31:0] p);
    cmd_t c;
    c.mode           = m;
    c.data_value     = d;
    c.priority_value = p;
    return c;
  endfunction

  // Priorities are often drawn from a few values so that ties are common.
  function automatic cmd_t pick_cmd(int insert_pct);
    cmd_t        c;
    int          roll;
    logic [31:0] p;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) c.mode = MODE_INSERT;
    else if (roll < 97) c.mode = ($urandom_range(0, 2) == 0) ? MODE_PEEK : MODE_REMOVE;
    else c.mode = MODE_CLEAR;
    case ($urandom_range(0, 3))
      0: p = $urandom();
      1: p = 32'($urandom_range(0, 7)) - 32'd4;
      2: begin
        case ($urandom_range(0, 3))
          0: p = 32'h7fff_ffff;
          1: p = 32'h8000_0000;
          2: p = 32'h0000_0000;
          default: p = 32'hffff_ffff;
        endcase
      end
      default: p = {$urandom_range(0, 1) ? 4'hf : 4'h0, 28'($urandom_range(0, 2))};
    endcase
    c.data_value     = $urandom();
    c.priority_value = p;
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(cmd_t c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      cmd_i <= pick_cmd(50);
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  logic [31:0] dir_prio [QUEUE_DEPTH] = '{
    32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
    32'h0000_0000, 32'h0000_0005, 32'h7fff_ffff, 32'h8000_0000,
    32'h0000_0005, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001,
    32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0002
  };

  initial begin
    logic [31:0] d;
    int          insert_pct;
    sb      = new;
    no_gaps = 1'b0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty queue: remove and peek underflow, clear is fine.
    send_cmd(mk_cmd(MODE_REMOVE, 32'd0, 32'd0));
    send_cmd(mk_cmd(MODE_PEEK, 32'd0, 32'd0));
    send_cmd(mk_cmd(MODE_CLEAR, 32'd0, 32'd0));
    // Fill with extreme and tied priorities, then overflow once.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0: d = 32'h7fff_ffff;
        1: d = 32'h8000_0000;
        2: d = 32'h0000_0000;
        3: d = 32'hffff_ffff;
        default: d = $urandom();
      endcase
      send_cmd(mk_cmd(MODE_INSERT, d, dir_prio[i]));
    end
    send_cmd(mk_cmd(MODE_INSERT, 32'h1234_5678, 32'h7fff_ffff));
    send_cmd(mk_cmd(MODE_PEEK, 32'd0, 32'd0));
    send_cmd(mk_cmd(MODE_REMOVE, 32'd0, 32'd0));
    send_cmd(mk_cmd(MODE_CLEAR, 32'd0, 32'd0));
    send_cmd(mk_cmd(MODE_REMOVE, 32'd0, 32'd0));
    drain();

    // Phases mostly lean toward filling or emptying so both ends are visited often.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % BLOCK_CMDS == 0) begin
        if ((n / BLOCK_CMDS) % 4 == 3) drain();
        case ($urandom_range(0, 2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      send_cmd(pick_cmd(insert_pct));
    end
    drain();
    repeat (4) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule
